>>> rtl/tdff_pkg.sv
// Shared types, sizes and helpers of the two-dimensional first-fit bitmap allocator.
// Used by tdff_ctrl, tdff_dpath and the top level; depends on nothing else.
`timescale 1ns / 1ps

package tdff_pkg;

   localparam int NUM_COLUMNS    = 512;
   localparam int NUM_ROW_GROUPS = 2;
   localparam int COL_W          = $clog2(NUM_COLUMNS);
   localparam int CNT_W          = COL_W + 1;
   localparam int ROW_W          = 1;
   localparam int HEIGHT_W       = 2;
   localparam int ROW_IDX_W      = (NUM_ROW_GROUPS > 1) ? $clog2(NUM_ROW_GROUPS) : 1;
   localparam int ALIGN_RESET    = 4;
   localparam int REQ_DATA_W     = 24;
   localparam int RSP_DATA_W     = 24;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef logic [NUM_ROW_GROUPS-1:0] occ_type;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_CLEAR,
      DP_LOAD,
      DP_SCAN_INIT,
      DP_FREE_INIT,
      DP_FAIL_INIT,
      DP_SCAN,
      DP_RMW
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_free;
      logic bad_alloc;
      logic hit;
      logic scan_end;
      logic rmw_done;
   } dp_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_RMW,
      ST_RESP
   } state_type;

   // Row groups covered by a rectangle of the given height whose lowest group is start.
   function automatic occ_type row_mask(input logic [HEIGHT_W-1:0] height, input int start);
      logic [NUM_ROW_GROUPS+3:0] ones;
      logic [NUM_ROW_GROUPS+3:0] shifted;
      ones    = (NUM_ROW_GROUPS + 4)'((1 << height) - 1);
      shifted = ones << start;
      return shifted[NUM_ROW_GROUPS-1:0];
   endfunction

endpackage

>>> rtl/tdff_ctrl.sv
// Controller of the allocator: sequences clearing, decode, scan, map update and response.
// Depends on tdff_pkg; drives the datapath through a command struct.
`timescale 1ns / 1ps

module tdff_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  tdff_pkg::dp_status_type status,
   output tdff_pkg::dp_cmd_type   cmd
);
   import tdff_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (status.is_free) begin
               state_in = ST_RMW;
            end else if (status.bad_alloc) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.hit) begin
               state_in = ST_RMW;
            end else if (status.scan_end) begin
               state_in = ST_RESP;
            end
         end
         ST_RMW: begin
            if (status.rmw_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd.op     = DP_NOP;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = DP_CLEAR;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = DP_LOAD;
         end
         ST_DECODE: begin
            if (status.is_free) begin
               cmd.op = DP_FREE_INIT;
            end else if (status.bad_alloc) begin
               cmd.op = DP_FAIL_INIT;
            end else begin
               cmd.op = DP_SCAN_INIT;
            end
         end
         ST_SCAN: begin
            cmd.op = DP_SCAN;
         end
         ST_RMW: begin
            cmd.op = DP_RMW;
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            cmd.op = DP_NOP;
         end
      endcase
   end

endmodule

>>> rtl/tdff_dpath.sv
// Datapath of the allocator: occupancy memory, request registers, free-run scan
// lanes, alignment phase, peak tracking and result registers. Depends on tdff_pkg.
`timescale 1ns / 1ps

module tdff_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tdff_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          req_tuser,
   output logic [tdff_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [tdff_pkg::CNT_W-1:0]    csr_wr_data,
   input  tdff_pkg::dp_cmd_type          cmd,
   output tdff_pkg::dp_status_type       status
);
   import tdff_pkg::*;

   // Occupancy memory: one entry per column, one bit per row group.
   occ_type mem [NUM_COLUMNS];
   occ_type rd_data_ff;
   logic    wr_en;
   logic [COL_W-1:0] wr_addr;
   occ_type wr_data;

   // Request fields.
   logic                cmd_ff;
   logic                srow_ff;
   logic [COL_W-1:0]    scol_ff;
   logic [CNT_W-1:0]    width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic                cvalid_ff;
   logic                crow_ff;

   logic [CNT_W-1:0] align_ff;
   logic [CNT_W-1:0] peak_ff, peak_in;
   logic [COL_W-1:0] clr_ptr_ff;

   // Read issue pointer, remaining reads, and the column whose data is in rd_data_ff.
   logic [COL_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic             vld_ff, vld_in;
   logic [COL_W-1:0] j_ff, j_in;

   logic [CNT_W-1:0] run_ff [NUM_ROW_GROUPS];
   logic [CNT_W-1:0] run_in [NUM_ROW_GROUPS];
   logic [CNT_W-1:0] phase_ff, phase_in;
   occ_type          mask_ff, mask_in;
   logic             mark_ff, mark_in;

   logic             res_granted_ff, res_granted_in;
   logic [ROW_W-1:0] res_row_ff, res_row_in;
   logic [COL_W-1:0] res_col_ff, res_col_in;

   // Scan evaluation.
   logic [CNT_W-1:0] run_next [NUM_ROW_GROUPS];
   occ_type          lane_mask [NUM_ROW_GROUPS];
   logic [NUM_ROW_GROUPS-1:0] fit;
   logic [ROW_IDX_W-1:0] hit_row;
   occ_type          hit_mask;
   logic [CNT_W-1:0] cand_end;
   logic [CNT_W-1:0] cand_col;
   logic             cand_ok;
   logic [CNT_W-1:0] align_eff;
   logic             issue;
   logic             hit;
   logic [CNT_W-1:0] free_room;
   logic             active;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_ptr_ff];
   end

   always_comb begin
      align_eff = (align_ff == '0) ? CNT_W'(1) : align_ff;
      cand_end  = {1'b0, j_ff} + CNT_W'(1);
      cand_ok   = cand_end >= width_ff;
      cand_col  = cand_end - width_ff;
      hit_row   = '0;
      hit_mask  = '0;
      for (int r = NUM_ROW_GROUPS - 1; r >= 0; r--) begin
         lane_mask[r] = row_mask(height_ff, r);
         run_next[r]  = ((rd_data_ff & lane_mask[r]) == '0) ? run_ff[r] + CNT_W'(1) : '0;
         fit[r] = (int'(height_ff) + r <= NUM_ROW_GROUPS) &&
                  (!cvalid_ff || int'(crow_ff) == r) &&
                  (run_next[r] >= width_ff);
         // Walking downward leaves the lowest fitting row group selected.
         if (fit[r]) begin
            hit_row  = ROW_IDX_W'(r);
            hit_mask = lane_mask[r];
         end
      end
      hit = (cmd.op == DP_SCAN) && vld_ff && cand_ok && (phase_ff == '0) && (|fit);
   end

   assign active    = (cmd.op == DP_SCAN) || (cmd.op == DP_RMW);
   assign issue     = active && (rem_ff != '0);
   assign free_room = CNT_W'(NUM_COLUMNS) - {1'b0, scol_ff};

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = j_ff;
      wr_data = mark_ff ? (rd_data_ff | mask_ff) : (rd_data_ff & ~mask_ff);
      if (cmd.op == DP_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ptr_ff;
         wr_data = '0;
      end else if (cmd.op == DP_RMW && vld_ff) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      rd_ptr_in      = rd_ptr_ff;
      rem_in         = rem_ff;
      vld_in         = issue;
      j_in           = rd_ptr_ff;
      run_in         = run_ff;
      phase_in       = phase_ff;
      mask_in        = mask_ff;
      mark_in        = mark_ff;
      peak_in        = peak_ff;
      res_granted_in = res_granted_ff;
      res_row_in     = res_row_ff;
      res_col_in     = res_col_ff;
      if (issue) begin
         rd_ptr_in = rd_ptr_ff + COL_W'(1);
         rem_in    = rem_ff - CNT_W'(1);
      end
      case (cmd.op)
         DP_SCAN_INIT: begin
            rd_ptr_in      = '0;
            rem_in         = CNT_W'(NUM_COLUMNS);
            phase_in       = '0;
            for (int r = 0; r < NUM_ROW_GROUPS; r++) run_in[r] = '0;
            res_granted_in = 1'b0;
            res_row_in     = '0;
            res_col_in     = '0;
         end
         DP_FAIL_INIT: begin
            res_granted_in = 1'b0;
            res_row_in     = '0;
            res_col_in     = '0;
         end
         DP_FREE_INIT: begin
            rd_ptr_in      = scol_ff;
            rem_in         = (width_ff < free_room) ? width_ff : free_room;
            mask_in        = row_mask(height_ff, int'(srow_ff));
            mark_in        = 1'b0;
            res_granted_in = 1'b1;
            res_row_in     = '0;
            res_col_in     = '0;
         end
         DP_SCAN: begin
            if (vld_ff) begin
               run_in = run_next;
               if (cand_ok) begin
                  phase_in = (phase_ff == align_eff - CNT_W'(1)) ? '0 : phase_ff + CNT_W'(1);
               end
            end
            // On a hit the read pointer is turned back to the found rectangle.
            if (hit) begin
               rd_ptr_in      = cand_col[COL_W-1:0];
               rem_in         = width_ff;
               vld_in         = 1'b0;
               mask_in        = hit_mask;
               mark_in        = 1'b1;
               res_granted_in = 1'b1;
               res_row_in     = ROW_W'(hit_row);
               res_col_in     = cand_col[COL_W-1:0];
               if (cand_end > peak_ff) peak_in = cand_end;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         align_ff   <= CNT_W'(ALIGN_RESET);
         peak_ff    <= '0;
         clr_ptr_ff <= '0;
         vld_ff     <= 1'b0;
         rem_ff     <= '0;
      end else begin
         if (csr_wr_en) align_ff <= csr_wr_data;
         if (cmd.op == DP_CLEAR) clr_ptr_ff <= clr_ptr_ff + COL_W'(1);
         peak_ff <= peak_in;
         vld_ff  <= vld_in;
         rem_ff  <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_LOAD) begin
         cmd_ff    <= req_tuser;
         srow_ff   <= req_tdata[0];
         scol_ff   <= req_tdata[9:1];
         width_ff  <= req_tdata[19:10];
         height_ff <= req_tdata[21:20];
         cvalid_ff <= req_tdata[22];
         crow_ff   <= req_tdata[23];
      end
      rd_ptr_ff      <= rd_ptr_in;
      j_ff           <= j_in;
      run_ff         <= run_in;
      phase_ff       <= phase_in;
      mask_ff        <= mask_in;
      mark_ff        <= mark_in;
      res_granted_ff <= res_granted_in;
      res_row_ff     <= res_row_in;
      res_col_ff     <= res_col_in;
   end

   assign status.clear_last = (clr_ptr_ff == COL_W'(NUM_COLUMNS - 1));
   assign status.is_free    = (cmd_ff == CMD_FREE);
   assign status.bad_alloc  = (width_ff == '0) || (width_ff > CNT_W'(NUM_COLUMNS)) ||
                              (height_ff == '0) || (int'(height_ff) > NUM_ROW_GROUPS);
   assign status.hit        = hit;
   assign status.scan_end   = vld_ff && (j_ff == COL_W'(NUM_COLUMNS - 1)) && !hit;
   assign status.rmw_done   = (rem_ff == '0) && !vld_ff;

   assign rsp_tdata = {{(RSP_DATA_W - 1 - ROW_W - COL_W - CNT_W){1'b0}},
                       peak_ff, res_col_ff, res_row_ff, res_granted_ff};

endmodule

>>> rtl/two_d_first_fit_bitmap_allocator_unit.sv
// Top level of the two-dimensional first-fit bitmap allocator.
// Depends on tdff_pkg, tdff_ctrl and tdff_dpath.
//
//   channel  direction  ports                        contents
//   req      in         req_tvalid/tready/tdata/tuser  one alloc or free request
//   rsp      out        rsp_tvalid/tready/tdata        grant, chunk position, peak
//   csr      in         csr_wr_en/csr_wr_data          column alignment register
//
// After reset the occupancy memory is cleared one column a cycle, and no request
// is taken before that ends. A valid allocation is accepted and decoded, scans
// the memory read port (one column a cycle) and, on a hit, marks the map;
// an invalid one goes straight to the response. A free is accepted, decoded
// and clears the freed columns. The response holds until rsp_tready.
`timescale 1ns / 1ps

module two_d_first_fit_bitmap_allocator_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // start_row[0], start_col[9:1], num_cols[19:10], num_row_groups[21:20],
   // row_constraint_valid[22], row_constraint[23]
   input  logic [tdff_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd[0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // granted[0], chunk_row[1], chunk_col[10:2], peak_cols[20:11], zero fill above
   output logic [tdff_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [tdff_pkg::CNT_W-1:0]      csr_wr_data
);
   import tdff_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   tdff_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   tdff_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (dp_cmd),
      .status      (dp_status)
   );

endmodule
